// File: sv/vmt_pkg.sv
// ----------------------------------------------------------------------------
// vmt_pkg
// Shared widths, types and item codes for the vertex matrix transform.
// ----------------------------------------------------------------------------
package vmt_pkg;

    // Fixed-point format of every component and matrix element
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Matrix shape
    localparam int DIM        = 4;
    localparam int NUM_ELEMS  = DIM * DIM;
    localparam int IDX_WIDTH  = $clog2(NUM_ELEMS);

    // Exact product, pair sum and four-term sum widths
    localparam int PROD_WIDTH = 2 * DATA_WIDTH;
    localparam int PAIR_WIDTH = PROD_WIDTH + 1;
    localparam int SUM_WIDTH  = PROD_WIDTH + 2;

    // Item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [PROD_WIDTH-1:0] prod_t;
    typedef logic signed [PAIR_WIDTH-1:0] pair_t;
    typedef logic signed [SUM_WIDTH-1:0]  sum_t;
    typedef logic        [IDX_WIDTH-1:0]  idx_t;

    typedef data_t matrix_t [NUM_ELEMS];
    typedef data_t vec_t    [DIM];
    typedef prod_t prods_t  [NUM_ELEMS];

    // Control that travels alongside a word in the pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

endpackage

// File: sv/vmt_matrix_store.sv
// ----------------------------------------------------------------------------
// vmt_matrix_store
// Sixteen-entry matrix register file, row-major, cleared at reset. One
// element is written per load word; all elements are read in parallel.
// ----------------------------------------------------------------------------
module vmt_matrix_store (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  vmt_pkg::idx_t    wr_index,
    input  vmt_pkg::data_t   wr_data,
    output vmt_pkg::matrix_t matrix
);
    import vmt_pkg::*;

    matrix_t matrix_reg;

    // Write one element per load word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ELEMS; i++)
            begin
                matrix_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            matrix_reg[wr_index] <= wr_data;
        end
    end

    assign matrix = matrix_reg;

`ifndef ASSERT_OFF
    // A written element holds the written value on the next cycle
    a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> matrix_reg[$past(wr_index)] == $past(wr_data))
        else $error("matrix element does not hold the loaded value");
`endif

endmodule

// File: sv/vmt_product_stage.sv
// ----------------------------------------------------------------------------
// vmt_product_stage
// First pipeline stage: forms all sixteen exact products v[j] * m[j][i]
// from the incoming vertex and the current matrix, and registers them.
// ----------------------------------------------------------------------------
module vmt_product_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vert_valid,
    input  vmt_pkg::vec_t    vec,
    input  logic             last,
    input  vmt_pkg::matrix_t matrix,
    input  logic             take,
    output logic             ready,
    output vmt_pkg::tag_t    tag,
    output vmt_pkg::prods_t  prods
);
    import vmt_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    logic   last_reg;
    prods_t prod_reg;
    prods_t prod_next;
    logic   load_en;

    // Stage may load when empty or when its word moves on
    assign load_en    = !valid_reg || take;
    assign ready      = load_en;
    assign valid_next = vert_valid;

    // Products: entry j*DIM+i holds component j times element (j, i)
    always_comb
    begin
        for (int j = 0; j < DIM; j++)
        begin
            for (int i = 0; i < DIM; i++)
            begin
                prod_next[j*DIM+i] = vec[j] * matrix[j*DIM+i];
            end
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_en)
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload only for a vertex word
    always_ff @(posedge clk)
    begin
        if (load_en && vert_valid)
        begin
            prod_reg <= prod_next;
            last_reg <= last;
        end
    end

    assign tag.valid = valid_reg;
    assign tag.last  = last_reg;
    assign prods     = prod_reg;

`ifndef ASSERT_OFF
    // A cycle that loads no vertex leaves the stage empty
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        load_en && !vert_valid |=> !valid_reg)
        else $error("product stage holds a word that was never accepted");
`endif

endmodule

// File: sv/vmt_reduce.sv
// ----------------------------------------------------------------------------
// vmt_reduce
// Remaining pipeline stages: pair sums per column, the four-term sum, then
// shift by the fraction width and saturate into the output register.
// ----------------------------------------------------------------------------
module vmt_reduce (
    input  logic            clk,
    input  logic            rst_n,
    input  vmt_pkg::tag_t   in_tag,
    input  vmt_pkg::prods_t prods,
    output logic            take,
    input  logic            result_stall,
    output logic            result_valid,
    output vmt_pkg::vec_t   result,
    output logic            result_last
);
    import vmt_pkg::*;

    localparam int HI_LSB = FRAC_BITS + DATA_WIDTH - 1;

    localparam data_t MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t MIN_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic  en2;
    logic  en3;
    logic  en4;

    tag_t  tag2_reg;
    tag_t  tag3_reg;
    tag_t  tag4_reg;

    pair_t lo_pair_reg [DIM];
    pair_t hi_pair_reg [DIM];
    pair_t lo_pair_next [DIM];
    pair_t hi_pair_next [DIM];
    sum_t  sum_reg [DIM];
    sum_t  sum_next [DIM];
    vec_t  res_reg;
    vec_t  res_next;
    logic [SUM_WIDTH-HI_LSB-1:0] hi_bits [DIM];

    // Each stage moves when empty or when the one after it moves
    assign en4  = !tag4_reg.valid || !result_stall;
    assign en3  = !tag3_reg.valid || en4;
    assign en2  = !tag2_reg.valid || en3;
    assign take = en2;

    // Stage two: rows 0+1 and rows 2+3 of each column
    always_comb
    begin
        for (int i = 0; i < DIM; i++)
        begin
            lo_pair_next[i] = PAIR_WIDTH'(prods[i]) + PAIR_WIDTH'(prods[DIM+i]);
            hi_pair_next[i] = PAIR_WIDTH'(prods[2*DIM+i]) + PAIR_WIDTH'(prods[3*DIM+i]);
        end
    end

    // Stage three: full column sum
    always_comb
    begin
        for (int i = 0; i < DIM; i++)
        begin
            sum_next[i] = SUM_WIDTH'(lo_pair_reg[i]) + SUM_WIDTH'(hi_pair_reg[i]);
        end
    end

    // Stage four: drop fraction bits, clamp to the data range
    always_comb
    begin
        for (int i = 0; i < DIM; i++)
        begin
            hi_bits[i] = sum_reg[i][SUM_WIDTH-1:HI_LSB];
            if ((&hi_bits[i]) || !(|hi_bits[i]))
            begin
                res_next[i] = sum_reg[i][HI_LSB:FRAC_BITS];
            end
            else if (sum_reg[i][SUM_WIDTH-1])
            begin
                res_next[i] = MIN_NEG;
            end
            else
            begin
                res_next[i] = MAX_POS;
            end
        end
    end

    // Advance valid bits and marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end
        else
        begin
            if (en2)
            begin
                tag2_reg <= in_tag;
            end
            if (en3)
            begin
                tag3_reg <= tag2_reg;
            end
            if (en4)
            begin
                tag4_reg <= tag3_reg;
            end
        end
    end

    // Advance payload, holding it while stalled
    always_ff @(posedge clk)
    begin
        if (en2 && in_tag.valid)
        begin
            lo_pair_reg <= lo_pair_next;
            hi_pair_reg <= hi_pair_next;
        end
        if (en3 && tag2_reg.valid)
        begin
            sum_reg <= sum_next;
        end
        if (en4 && tag3_reg.valid)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = tag4_reg.valid;
    assign result_last  = tag4_reg.last;
    assign result       = res_reg;

endmodule

// File: sv/vertex_matrix_transform.sv
// ----------------------------------------------------------------------------
// vertex_matrix_transform
// Homogeneous 4x4 matrix transform of a vertex stream, signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid / item_stall) carries one word per cycle while item_stall is low.
//   kind selects the word: a load word writes matrix element elem_index
//   (row * 4 + column) with elem_value and gives no result; a vertex word
//   gives one result out = v * M on the result channel (result_valid /
//   result_stall), with out_last copying last_vertex.
//   Throughput: one word per cycle while item_stall is low, loads and vertices mixed freely.
//   Pipeline: an accepted vertex loads the product register at the accept
//   edge, then passes through the pair sum, column sum and shift/saturate
//   registers to the result port.
//   The products are formed at the accept edge, so a vertex sees every
//   load accepted before it and none accepted after it.
//   Reset clears the matrix to zero and empties the pipeline.
//   When the receiver stalls, the result holds and the pipeline fills;
//   item_stall rises only once all four stages hold words.
// ----------------------------------------------------------------------------
module vertex_matrix_transform (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic                  kind,
    input  vmt_pkg::idx_t         elem_index,
    input  vmt_pkg::data_t        elem_value,
    input  vmt_pkg::data_t        vec_x,
    input  vmt_pkg::data_t        vec_y,
    input  vmt_pkg::data_t        vec_z,
    input  vmt_pkg::data_t        vec_w,
    input  logic                  last_vertex,
    output logic                  result_valid,
    input  logic                  result_stall,
    output vmt_pkg::data_t        out_x,
    output vmt_pkg::data_t        out_y,
    output vmt_pkg::data_t        out_z,
    output vmt_pkg::data_t        out_w,
    output logic                  out_last
);
    import vmt_pkg::*;

    logic    ready;
    logic    take;
    logic    item_accept;
    logic    load_wr;
    logic    vert_valid;
    matrix_t matrix;
    vec_t    vec;
    vec_t    result;
    tag_t    prod_tag;
    prods_t  prods;

    // Decode the input word
    assign item_stall  = !ready;
    assign item_accept = item_valid && ready;
    assign load_wr     = item_accept && (kind == KIND_LOAD);
    assign vert_valid  = item_valid && (kind == KIND_VERTEX);

    assign vec[0] = vec_x;
    assign vec[1] = vec_y;
    assign vec[2] = vec_z;
    assign vec[3] = vec_w;

    vmt_matrix_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (load_wr),
        .wr_index (elem_index),
        .wr_data  (elem_value),
        .matrix   (matrix)
    );

    vmt_product_stage u_prod (
        .clk        (clk),
        .rst_n      (rst_n),
        .vert_valid (vert_valid),
        .vec        (vec),
        .last       (last_vertex),
        .matrix     (matrix),
        .take       (take),
        .ready      (ready),
        .tag        (prod_tag),
        .prods      (prods)
    );

    vmt_reduce u_reduce (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_tag       (prod_tag),
        .prods        (prods),
        .take         (take),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .result_last  (out_last)
    );

    assign out_x = result[0];
    assign out_y = result[1];
    assign out_z = result[2];
    assign out_w = result[3];

`ifndef ASSERT_OFF
    // Input backs up only behind a full pipeline and a stalled receiver
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall && prod_tag.valid))
        else $error("input stalled while the pipeline has room");
`endif

endmodule

// File: sim/tb_vertex_matrix_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_matrix_transform
// Self-checking bench for the 4x4 homogeneous vertex transform. A driver
// feeds matrix loads and vertices from a queue of pending words and keeps a
// shadow of the matrix to predict each transformed vertex at its accept edge.
// A monitor compares every result word, field by field, with the oldest
// prediction. Both channels idle and stall in random bursts, the receiver
// holds off long enough to back the pipeline up, and the sender pauses for
// a full drain now and then.
// ----------------------------------------------------------------------------
module tb_vertex_matrix_transform;

    import vmt_pkg::*;

    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  RANDOM_ITEMS  = 1600;
    localparam int  QUIET_TAIL    = 200;
    localparam int  HOLD_CYCLES   = 60;
    localparam int  PRINT_CAP     = 100;

    localparam data_t DMAX   = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam data_t DMIN   = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam data_t FX_ONE = data_t'(1) <<< FRAC_BITS;

    localparam sum_t SAT_MAX = (sum_t'(1) <<< (DATA_WIDTH-1)) - 1;
    localparam sum_t SAT_MIN = -(sum_t'(1) <<< (DATA_WIDTH-1));

    // One word on the input channel, plus a flag to wait for a full drain
    typedef struct {
        logic  kind;
        idx_t  index;
        data_t value;
        data_t vx;
        data_t vy;
        data_t vz;
        data_t vw;
        logic  last;
        bit    wait_drain;
    } feed_word_t;

    typedef struct {
        data_t x;
        data_t y;
        data_t z;
        data_t w;
        logic  last;
    } vertex_out_t;

    logic  clk;
    logic  rst_n        = 1'b0;
    logic  item_valid   = 1'b0;
    logic  item_stall;
    logic  kind         = KIND_LOAD;
    idx_t  elem_index   = '0;
    data_t elem_value   = '0;
    data_t vec_x        = '0;
    data_t vec_y        = '0;
    data_t vec_z        = '0;
    data_t vec_w        = '0;
    logic  last_vertex  = 1'b0;
    logic  result_valid;
    logic  result_stall = 1'b0;
    data_t out_x;
    data_t out_y;
    data_t out_z;
    data_t out_w;
    logic  out_last;

    feed_word_t  pending_words[$];
    vertex_out_t expected_vertices[$];
    data_t       matrix_shadow [NUM_ELEMS];

    int  total_items     = 0;
    int  items_accepted  = 0;
    int  results_checked = 0;
    int  error_count     = 0;
    int  cycle_count     = 0;
    int  send_gap        = 0;
    int  stall_left      = 0;
    int  hold_left       = 0;
    int  holds_done      = 0;
    logic hold_off_active = 1'b0;

    vertex_matrix_transform u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .elem_index   (elem_index),
        .elem_value   (elem_value),
        .vec_x        (vec_x),
        .vec_y        (vec_y),
        .vec_z        (vec_z),
        .vec_w        (vec_w),
        .last_vertex  (last_vertex),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z),
        .out_w        (out_w),
        .out_last     (out_last)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Row vector times shadow matrix: exact products, exact sum, floor shift,
    // then clamp to the data range
    function automatic vertex_out_t transform_vertex(input feed_word_t wd);
        data_t       comp [DIM];
        data_t       res  [DIM];
        sum_t        acc;
        sum_t        a;
        sum_t        b;
        vertex_out_t r;
        comp = '{wd.vx, wd.vy, wd.vz, wd.vw};
        for (int col = 0; col < DIM; col++)
        begin
            acc = '0;
            for (int row = 0; row < DIM; row++)
            begin
                a = comp[row];
                b = matrix_shadow[row * DIM + col];
                acc = acc + a * b;
            end
            acc = acc >>> FRAC_BITS;
            if (acc > SAT_MAX)
                res[col] = DMAX;
            else if (acc < SAT_MIN)
                res[col] = DMIN;
            else
                res[col] = acc[DATA_WIDTH-1:0];
        end
        r.x    = res[0];
        r.y    = res[1];
        r.z    = res[2];
        r.w    = res[3];
        r.last = wd.last;
        return r;
    endfunction

    // Idling is off in calm stretches and in the tail of the run
    function automatic bit idling_on();
        return (items_accepted + QUIET_TAIL < total_items) &&
               ((items_accepted / 150) % 4 != 3);
    endfunction

    function automatic idx_t elem(input int row, input int col);
        return idx_t'(row * DIM + col);
    endfunction

    // Mix of extremes, full-range words and values within +/- 2^span
    function automatic data_t random_fixed(input int span);
        logic [31:0] raw;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 5))
                    0: return DMAX;
                    1: return DMIN;
                    2: return '0;
                    3: return -data_t'(1);
                    4: return FX_ONE;
                    default: return -FX_ONE;
                endcase
            end
            1, 2: return data_t'($urandom);
            default:
            begin
                raw = $urandom & ((32'd1 << (span + 1)) - 1);
                return data_t'(raw) - (data_t'(1) <<< span);
            end
        endcase
    endfunction

    // Loads carry junk in the vertex fields, vertices junk in the element fields
    function automatic feed_word_t make_load(input idx_t idx, input data_t val);
        feed_word_t wd;
        wd.kind       = KIND_LOAD;
        wd.index      = idx;
        wd.value      = val;
        wd.vx         = data_t'($urandom);
        wd.vy         = data_t'($urandom);
        wd.vz         = data_t'($urandom);
        wd.vw         = data_t'($urandom);
        wd.last       = 1'($urandom_range(0, 1));
        wd.wait_drain = 1'b0;
        return wd;
    endfunction

    function automatic feed_word_t make_vertex(input data_t x, input data_t y,
                                               input data_t z, input data_t w,
                                               input logic  last);
        feed_word_t wd;
        wd.kind       = KIND_VERTEX;
        wd.index      = idx_t'($urandom);
        wd.value      = data_t'($urandom);
        wd.vx         = x;
        wd.vy         = y;
        wd.vz         = z;
        wd.vw         = w;
        wd.last       = last;
        wd.wait_drain = 1'b0;
        return wd;
    endfunction

    task automatic log_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input data_t got, input data_t want);
        if (got !== want)
            log_mismatch($sformatf("result %0d %s got %h want %h",
                                   results_checked, name, got, want));
    endtask

    // Driver: take the accepted word into the shadow matrix or the
    // prediction queue, then offer the next pending word
    always @(posedge clk or negedge rst_n)
    begin : driver
        feed_word_t head;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            items_accepted <= 0;
            send_gap = 0;
            for (int k = 0; k < NUM_ELEMS; k++)
                matrix_shadow[k] = '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                head = pending_words.pop_front();
                if (head.kind == KIND_LOAD)
                    matrix_shadow[head.index] = head.value;
                else
                    expected_vertices.push_back(transform_vertex(head));
                items_accepted <= items_accepted + 1;
                if (idling_on() && !hold_off_active && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 9);
            end
            // Hold a stalled word; otherwise idle, pause or present the next
            if (!(item_valid && item_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (pending_words.size() == 0)
                    item_valid <= 1'b0;
                else if (pending_words[0].wait_drain && expected_vertices.size() != 0)
                    item_valid <= 1'b0;
                else
                begin
                    kind        <= pending_words[0].kind;
                    elem_index  <= pending_words[0].index;
                    elem_value  <= pending_words[0].value;
                    vec_x       <= pending_words[0].vx;
                    vec_y       <= pending_words[0].vy;
                    vec_z       <= pending_words[0].vz;
                    vec_w       <= pending_words[0].vw;
                    last_vertex <= pending_words[0].last;
                    item_valid  <= 1'b1;
                end
            end
        end
    end

    // Monitor: check each accepted result, then choose the next stall
    always @(posedge clk or negedge rst_n)
    begin : monitor
        vertex_out_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_vertices.size() == 0)
                    log_mismatch($sformatf("result %0d with no vertex pending: %h %h %h %h %b",
                                           results_checked, out_x, out_y, out_z, out_w,
                                           out_last));
                else
                begin
                    want = expected_vertices.pop_front();
                    check_field("out_x", out_x, want.x);
                    check_field("out_y", out_y, want.y);
                    check_field("out_z", out_z, want.z);
                    check_field("out_w", out_w, want.w);
                    check_field("out_last", data_t'(out_last), data_t'(want.last));
                end
                results_checked++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (hold_off_active)
                result_stall <= 1'b1;
            else if (idling_on() && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                result_stall <= 1'b1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    // Long receiver hold-off, twice in the run, so the pipeline backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off_active <= 1'b0;
            hold_left = 0;
            holds_done = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            if (hold_left == 0)
                hold_off_active <= 1'b0;
        end
        else if (holds_done < 2 && items_accepted >= 450 + holds_done * 600)
        begin
            hold_left = HOLD_CYCLES;
            hold_off_active <= 1'b1;
            holds_done++;
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Build the stimulus, release reset, wait for the drain and report
    initial
    begin : stimulus
        feed_word_t wd;
        int         n;
        bit         first_random;

        // Zero matrix after reset, then a unit diagonal
        pending_words.push_back(make_vertex(FX_ONE, FX_ONE, FX_ONE, FX_ONE, 1'b1));
        for (int d = 0; d < DIM; d++)
            pending_words.push_back(make_load(elem(d, d), FX_ONE));
        pending_words.push_back(make_vertex(DMAX, DMIN, -data_t'(1), FX_ONE + (FX_ONE >>> 1),
                                            1'b0));
        // Extreme off-diagonal elements: saturate both ways
        pending_words.push_back(make_load(elem(0, 1), DMAX));
        pending_words.push_back(make_load(elem(1, 0), DMIN));
        pending_words.push_back(make_vertex(DMAX, DMAX, '0, '0, 1'b0));
        pending_words.push_back(make_vertex(DMIN, DMIN, '0, '0, 1'b1));
        // Tiny element: floor of a negative fraction
        pending_words.push_back(make_load(elem(0, 0), data_t'(1)));
        pending_words.push_back(make_vertex(-data_t'(1), '0, '0, '0, 1'b1));
        pending_words.push_back(make_load(elem(3, 3), '0));
        pending_words.push_back(make_load(elem(3, 2), DMIN));
        pending_words.push_back(make_load(elem(0, 3), DMAX));
        pending_words.push_back(make_vertex(DMIN, DMIN, DMIN, DMIN, 1'b1));
        pending_words.push_back(make_vertex(DMAX, DMAX, DMAX, DMAX, 1'b0));
        pending_words.push_back(make_vertex('0, '0, '0, '0, 1'b1));

        // Random part: mostly vertex buffers, with full and partial matrix reloads and mixed words
        first_random = 1'b1;
        while (pending_words.size() < RANDOM_ITEMS + 20)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    for (int k = 0; k < NUM_ELEMS; k++)
                    begin
                        wd = make_load(idx_t'(k), random_fixed(18));
                        wd.wait_drain = first_random || (k == 0 && $urandom_range(0, 3) == 0);
                        first_random = 1'b0;
                        pending_words.push_back(wd);
                    end
                end
                2, 3:
                begin
                    n = $urandom_range(1, 4);
                    for (int k = 0; k < n; k++)
                        pending_words.push_back(make_load(idx_t'($urandom), random_fixed(18)));
                end
                4, 5, 6, 7, 8:
                begin
                    n = $urandom_range(1, 24);
                    for (int k = 0; k < n; k++)
                        pending_words.push_back(make_vertex(random_fixed(26), random_fixed(26),
                                                            random_fixed(26), random_fixed(26),
                                                            k == n - 1));
                end
                default:
                begin
                    n = $urandom_range(1, 6);
                    for (int k = 0; k < n; k++)
                    begin
                        wd = make_vertex(data_t'($urandom), data_t'($urandom),
                                         data_t'($urandom), data_t'($urandom),
                                         1'($urandom_range(0, 1)));
                        if ($urandom_range(0, 1) == 0)
                            wd = make_load(idx_t'($urandom), data_t'($urandom));
                        pending_words.push_back(wd);
                    end
                end
            endcase
        end
        total_items = pending_words.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (!(items_accepted == total_items && expected_vertices.size() == 0))
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0 && expected_vertices.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: vertex_matrix_transform.f
sv/vmt_pkg.sv
sv/vmt_matrix_store.sv
sv/vmt_product_stage.sv
sv/vmt_reduce.sv
sv/vertex_matrix_transform.sv
sim/tb_vertex_matrix_transform.sv
